// File: rtl/midpoint_line_rasterizer_assert.svh
// Assertion macros for the line rasterizer RTL.
// Uses clk_i and rst_ni of the including module; empty under SYNTHESIS.
`ifndef MIDPOINT_LINE_RASTERIZER_ASSERT_SVH
`define MIDPOINT_LINE_RASTERIZER_ASSERT_SVH

`ifndef SYNTHESIS
`define MLR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define MLR_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MLR_ASSERT(lbl, prop, msg)
`define MLR_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/mlr_pkg.sv
// Shared types and constants of the line rasterizer.
// No dependencies.
package mlr_pkg;

  localparam int unsigned COORD_BITS_DEF = 12;
  localparam int unsigned CLIP_W         = 11;
  localparam int unsigned CFG_IDX_W      = 2;

  localparam logic [CLIP_W-1:0] CLIP_X_RESET = 11'd1919;
  localparam logic [CLIP_W-1:0] CLIP_Y_RESET = 11'd1079;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_X_MAX = 2'd0,
    CFG_CLIP_Y_MAX = 2'd1
  } cfg_idx_e;

  typedef enum logic {
    REQ_LOAD = 1'b0,
    REQ_STEP = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    OCT_SHALLOW_FALL = 2'd0,
    OCT_SHALLOW_RISE = 2'd1,
    OCT_STEEP_RISE   = 2'd2,
    OCT_STEEP_FALL   = 2'd3
  } oct_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_SETUP = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic load;        // capture endpoints and deltas
    logic setup;       // classify octant, init decision
    logic step_draw;   // emit next pixel of the active line
    logic step_empty;  // emit a no-pixel result
  } dp_cmd_t;

  typedef struct packed {
    logic line_active;
  } dp_sts_t;

endpackage

// File: rtl/mlr_ctrl.sv
// Request sequencer of the line rasterizer.
// Depends on mlr_pkg.
module mlr_ctrl import mlr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  logic    req_type_i,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o,
  output logic    busy_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          if (req_type_i == REQ_LOAD) begin
            cmd_o.load = 1'b1;
            state_d    = ST_SETUP;
          end else if (sts_i.line_active) begin
            cmd_o.step_draw = 1'b1;
          end else begin
            cmd_o.step_empty = 1'b1;
          end
        end
      end
      ST_SETUP: begin
        busy_o      = 1'b1;
        cmd_o.setup = 1'b1;
        state_d     = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/mlr_datapath.sv
// Line rasterizer datapath: clip registers, line setup, decision stepping, result regs.
// Depends on mlr_pkg and midpoint_line_rasterizer_assert.svh.
`include "midpoint_line_rasterizer_assert.svh"
module mlr_datapath import mlr_pkg::*; #(
  parameter int unsigned CoordBits = COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  dp_cmd_t                     cmd_i,
  output dp_sts_t                     sts_o,
  input  logic                        cfg_we_i,
  input  logic [CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [CLIP_W-1:0]           cfg_data_i,
  input  logic signed [CoordBits-1:0] start_x_i,
  input  logic signed [CoordBits-1:0] start_y_i,
  input  logic signed [CoordBits-1:0] end_x_i,
  input  logic signed [CoordBits-1:0] end_y_i,
  output logic                        pixel_valid_o,
  output logic signed [CoordBits-1:0] pixel_x_o,
  output logic signed [CoordBits-1:0] pixel_y_o,
  output logic                        pixel_visible_o,
  output logic                        last_pixel_o,
  output logic                        no_pixel_o
);

  localparam int unsigned EW     = CoordBits + 2;  // deltas and their negation
  localparam int unsigned MOVE_W = CoordBits + 3;
  localparam int unsigned DEC_W  = CoordBits + 4;
  localparam int unsigned VW     = ((CoordBits > CLIP_W) ? CoordBits : CLIP_W) + 2;

  // clip window
  logic [CLIP_W-1:0] clip_x_q, clip_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_x_q <= CLIP_X_RESET;
      clip_y_q <= CLIP_Y_RESET;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_CLIP_X_MAX) clip_x_q <= cfg_data_i;
      if (cfg_index_i == CFG_CLIP_Y_MAX) clip_y_q <= cfg_data_i;
    end
  end

  // endpoint capture
  logic signed [CoordBits-1:0] sx_q, sy_q, ex_q, ey_q;
  logic signed [EW-1:0]        dx_q, dy_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q <= start_x_i;
      sy_q <= start_y_i;
      ex_q <= end_x_i;
      ey_q <= end_y_i;
      dx_q <= EW'(end_x_i) - EW'(start_x_i);
      dy_q <= EW'(end_y_i) - EW'(start_y_i);
    end
  end

  // octant setup
  logic signed [EW-1:0]        ndx, ndy, run, rise;
  logic signed [CoordBits-1:0] mstart, mend;
  logic signed [DEC_W-1:0]     num, num_adj;
  oct_e                        oct_init;

  always_comb begin
    ndx = -dx_q;
    ndy = -dy_q;
    if ((!dx_q[EW-1] && !(dy_q > 0) && dx_q >= ndy) ||
        (!(dx_q > 0) && !dy_q[EW-1] && ndx >= dy_q)) begin
      oct_init = OCT_SHALLOW_FALL;
      run = dx_q;  rise = ndy;
      mstart = sx_q; mend = ex_q;
    end else if ((dx_q > 0 && dy_q > 0 && dx_q >= dy_q) ||
                 (dx_q[EW-1] && dy_q[EW-1] && ndx >= ndy)) begin
      oct_init = OCT_SHALLOW_RISE;
      run = dx_q;  rise = dy_q;
      mstart = sx_q; mend = ex_q;
    end else if ((!dy_q[EW-1] && !dx_q[EW-1] && dx_q < dy_q) ||
                 (!(dy_q > 0) && !(dx_q > 0) && ndx < ndy)) begin
      oct_init = OCT_STEEP_RISE;
      run = ndy;   rise = ndx;
      mstart = sy_q; mend = ey_q;
    end else begin
      oct_init = OCT_STEEP_FALL;
      run = ndy;   rise = dx_q;
      mstart = sy_q; mend = ey_q;
    end
    num     = (DEC_W'(rise) <<< 1) - DEC_W'(run);
    // halve toward zero: bias negatives up by one
    num_adj = num + $signed({{(DEC_W-1){1'b0}}, num[DEC_W-1]});
  end

  // line state
  logic signed [CoordBits-1:0] cur_x_q, cur_y_q, major_end_q;
  logic signed [DEC_W-1:0]     decision_q;
  logic signed [EW-1:0]        inc_keep_q;
  logic signed [MOVE_W-1:0]    inc_move_q;
  oct_e                        oct_q;
  logic                        rev_q, line_active_q;

  // step
  logic                        fwd, major_x, take, minor_neg, last;
  logic                        vis_x, vis_y;
  logic signed [CoordBits-1:0] major_cur, major_nxt, minor_cur, minor_nxt;
  logic signed [VW-1:0]        px_v, py_v;

  always_comb begin
    fwd       = !rev_q;
    major_x   = (oct_q == OCT_SHALLOW_FALL) || (oct_q == OCT_SHALLOW_RISE);
    minor_neg = ((oct_q == OCT_SHALLOW_FALL) || (oct_q == OCT_STEEP_FALL)) ? fwd : !fwd;
    if (major_x == fwd) begin
      take = !decision_q[DEC_W-1];
    end else begin
      take = decision_q[DEC_W-1] || (decision_q == '0);
    end
    major_cur = major_x ? cur_x_q : cur_y_q;
    minor_cur = major_x ? cur_y_q : cur_x_q;
    major_nxt = fwd ? major_cur + CoordBits'(1) : major_cur - CoordBits'(1);
    if (take) begin
      minor_nxt = minor_neg ? minor_cur - CoordBits'(1) : minor_cur + CoordBits'(1);
    end else begin
      minor_nxt = minor_cur;
    end
    last  = (major_nxt == major_end_q);
    px_v  = VW'(cur_x_q);
    py_v  = VW'(cur_y_q);
    vis_x = (px_v > 0) && (px_v <= $signed(VW'(clip_x_q)));
    vis_y = (py_v > 0) && (py_v <= $signed(VW'(clip_y_q)));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q       <= '0;
      cur_y_q       <= '0;
      major_end_q   <= '0;
      decision_q    <= '0;
      inc_keep_q    <= '0;
      inc_move_q    <= '0;
      oct_q         <= OCT_SHALLOW_FALL;
      rev_q         <= 1'b0;
      line_active_q <= 1'b0;
    end else if (cmd_i.setup) begin
      cur_x_q       <= sx_q;
      cur_y_q       <= sy_q;
      major_end_q   <= mend;
      decision_q    <= num_adj >>> 1;
      inc_keep_q    <= rise;
      inc_move_q    <= MOVE_W'(rise) - MOVE_W'(run);
      oct_q         <= oct_init;
      rev_q         <= !(mstart < mend);
      line_active_q <= (mstart != mend);
    end else if (cmd_i.step_draw) begin
      decision_q <= take ? decision_q + DEC_W'(inc_move_q)
                         : decision_q + DEC_W'(inc_keep_q);
      if (major_x) begin
        cur_x_q <= major_nxt;
        cur_y_q <= minor_nxt;
      end else begin
        cur_y_q <= major_nxt;
        cur_x_q <= minor_nxt;
      end
      if (last) line_active_q <= 1'b0;
    end
  end

  assign sts_o.line_active = line_active_q;

  // result register
  logic                        valid_q, vis_q, last_q, none_q;
  logic signed [CoordBits-1:0] px_q, py_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cmd_i.step_draw || cmd_i.step_empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step_draw) begin
      px_q   <= cur_x_q;
      py_q   <= cur_y_q;
      vis_q  <= vis_x && vis_y;
      last_q <= last;
      none_q <= 1'b0;
    end else if (cmd_i.step_empty) begin
      px_q   <= '0;
      py_q   <= '0;
      vis_q  <= 1'b0;
      last_q <= 1'b0;
      none_q <= 1'b1;
    end
  end

  assign pixel_valid_o   = valid_q;
  assign pixel_x_o       = px_q;
  assign pixel_y_o       = py_q;
  assign pixel_visible_o = vis_q;
  assign last_pixel_o    = last_q;
  assign no_pixel_o      = none_q;

  `MLR_ASSERT(a_result_follows_step, valid_q |-> $past(cmd_i.step_draw || cmd_i.step_empty), "result strobe without a step request")
  `MLR_ASSERT(a_last_ends_line, (valid_q && last_q) |-> !line_active_q, "line still active after last pixel")
  `MLR_ASSERT(a_empty_is_blank, (valid_q && none_q) |-> (!vis_q && !last_q), "no-pixel result flagged visible or last")
  `MLR_ASSERT_NEVER(a_step_without_line, cmd_i.step_draw && !line_active_q, "pixel step with no active line")

endmodule

// File: rtl/midpoint_line_rasterizer.sv
// Midpoint line rasterizer with clip-window visibility flag.
//
// Request channel: start_i with req_type_i and the endpoint fields; a request is
// taken on a rising edge with start_i high and busy_o low.
//   Load request: latches the endpoints, then spends a setup state classifying
//   the octant and seeding the decision value; busy_o is high during setup.
//   A load produces no result. A load of a zero-length line leaves no line active.
//   Step request: one result per step; steps may be issued every clock while busy_o is low.
// Result channel: pixel_valid_o pulses for one cycle, the cycle after the step
// request, with pixel_x_o/pixel_y_o, pixel_visible_o, last_pixel_o, no_pixel_o.
// The receiver cannot stall; results must be consumed when the strobe is high.
// Throughput: one pixel per clock while busy_o is low, set by the single add and
// compare on the decision register. A load captures the endpoints, then runs setup.
// Config channel: cfg_valid_i/cfg_ready_o with cfg_index_i (0 clip x max,
// 1 clip y max, other indexes ignored) and cfg_data_i; always ready.
// Reset: clip window 1919 x 1079, no line active, no result pending.
// Depends on mlr_pkg, mlr_ctrl, mlr_datapath.
module midpoint_line_rasterizer import mlr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic                         req_type_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  output logic                         pixel_valid_o,
  output logic signed [COORD_BITS-1:0] pixel_x_o,
  output logic signed [COORD_BITS-1:0] pixel_y_o,
  output logic                         pixel_visible_o,
  output logic                         last_pixel_o,
  output logic                         no_pixel_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CLIP_W-1:0]            cfg_data_i
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready_o = 1'b1;

  mlr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .req_type_i (req_type_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .busy_o     (busy_o)
  );

  mlr_datapath #(
    .CoordBits (COORD_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .start_x_i       (start_x_i),
    .start_y_i       (start_y_i),
    .end_x_i         (end_x_i),
    .end_y_i         (end_y_i),
    .pixel_valid_o   (pixel_valid_o),
    .pixel_x_o       (pixel_x_o),
    .pixel_y_o       (pixel_y_o),
    .pixel_visible_o (pixel_visible_o),
    .last_pixel_o    (last_pixel_o),
    .no_pixel_o      (no_pixel_o)
  );

endmodule

// File: dv/midpoint_line_rasterizer_checker.sv
`timescale 1ns / 100ps
// Checker for midpoint_line_rasterizer: watches the request, clip and pixel channels,
// predicts each step's pixel and compares results in order. Depends on mlr_pkg.
module midpoint_line_rasterizer_checker import mlr_pkg::*; #(
  parameter int unsigned COORD_BITS = COORD_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic                         busy_i,
  input  logic                         req_type_i,
  input  logic signed [COORD_BITS-1:0] start_x_i,
  input  logic signed [COORD_BITS-1:0] start_y_i,
  input  logic signed [COORD_BITS-1:0] end_x_i,
  input  logic signed [COORD_BITS-1:0] end_y_i,
  input  logic                         pixel_valid_i,
  input  logic signed [COORD_BITS-1:0] pixel_x_i,
  input  logic signed [COORD_BITS-1:0] pixel_y_i,
  input  logic                         pixel_visible_i,
  input  logic                         last_pixel_i,
  input  logic                         no_pixel_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [CLIP_W-1:0]            cfg_data_i,
  output int                           mismatch_count_o,
  output int                           pending_o
);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         visible;
    logic                         last;
    logic                         no_pixel;
  } pixel_t;

  logic [CLIP_W-1:0]            clip_x, clip_y;
  logic signed [COORD_BITS-1:0] cur_x, cur_y, major_end;
  logic signed [15:0]           decision;
  logic signed [13:0]           inc_keep;
  logic signed [14:0]           inc_move;
  oct_e                         octant;
  logic                         reverse, active;
  pixel_t                       pixel_q[$];

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count_o++;
    if (mismatch_count_o <= 40) begin
      $display("%0t: %s got %0d, want %0d", $time, what, got, want);
    end
  endtask

  task automatic setup_line(input int sx, input int sy, input int ex, input int ey);
    int dx, dy, run, rise, mstart, mend;
    dx = ex - sx;
    dy = ey - sy;
    // exact up-left diagonal lands in shallow falling on purpose
    if ((dx >= 0 && dy <= 0 && dx >= -dy) || (dx <= 0 && dy >= 0 && -dx >= dy)) begin
      octant = OCT_SHALLOW_FALL; run = dx; rise = -dy; mstart = sx; mend = ex;
    end else if ((dx > 0 && dy > 0 && dx >= dy) || (dx < 0 && dy < 0 && -dx >= -dy)) begin
      octant = OCT_SHALLOW_RISE; run = dx; rise = dy; mstart = sx; mend = ex;
    end else if ((dy >= 0 && dx >= 0 && dx < dy) || (dy <= 0 && dx <= 0 && -dx < -dy)) begin
      octant = OCT_STEEP_RISE; run = -dy; rise = -dx; mstart = sy; mend = ey;
    end else begin
      octant = OCT_STEEP_FALL; run = -dy; rise = dx; mstart = sy; mend = ey;
    end
    decision  = 16'((2 * rise - run) / 2);  // int division truncates toward zero
    inc_keep  = 14'(rise);
    inc_move  = 15'(rise - run);
    cur_x     = COORD_BITS'(sx);
    cur_y     = COORD_BITS'(sy);
    major_end = COORD_BITS'(mend);
    reverse   = !(mstart < mend);
    active    = (mstart != mend);
  endtask

  task automatic trace_pixel(output pixel_t px);
    int   x, y, dec, mdelta;
    logic fwd, steep, take;
    px = '0;
    if (!active) begin
      px.no_pixel = 1'b1;
    end else begin
      x = cur_x;
      y = cur_y;
      px.x = cur_x;
      px.y = cur_y;
      px.visible = x >= 1 && x <= int'(clip_x) && y >= 1 && y <= int'(clip_y);
      fwd   = !reverse;
      steep = (octant == OCT_STEEP_RISE) || (octant == OCT_STEEP_FALL);
      dec   = decision;
      if (!steep) take = fwd ? (dec >= 0) : (dec <= 0);
      else        take = fwd ? (dec <= 0) : (dec >= 0);
      if (octant == OCT_SHALLOW_FALL || octant == OCT_STEEP_FALL) mdelta = fwd ? -1 : 1;
      else                                                        mdelta = fwd ? 1 : -1;
      // clipped pixels advance the decision just like visible ones
      if (take) begin
        decision = 16'(dec + inc_move);
        if (steep) x += mdelta;
        else       y += mdelta;
      end else begin
        decision = 16'(dec + inc_keep);
      end
      if (steep) y += fwd ? 1 : -1;
      else       x += fwd ? 1 : -1;
      px.last = steep ? (y == major_end) : (x == major_end);
      cur_x = COORD_BITS'(x);
      cur_y = COORD_BITS'(y);
      if (px.last) active = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t want;
    if (!rst_ni) begin
      clip_x    = CLIP_X_RESET;
      clip_y    = CLIP_Y_RESET;
      cur_x     = '0;
      cur_y     = '0;
      major_end = '0;
      decision  = '0;
      inc_keep  = '0;
      inc_move  = '0;
      octant    = OCT_SHALLOW_FALL;
      reverse   = 1'b0;
      active    = 1'b0;
      pixel_q.delete();
      mismatch_count_o = 0;
      pending_o <= 0;
    end else begin
      if (pixel_valid_i) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("pixel with no request pending:", 1, 0);
        end else begin
          want = pixel_q.pop_front();
          if (pixel_x_i !== want.x)
            report_mismatch("pixel_x", pixel_x_i, $signed(want.x));
          if (pixel_y_i !== want.y)
            report_mismatch("pixel_y", pixel_y_i, $signed(want.y));
          if (pixel_visible_i !== want.visible)
            report_mismatch("pixel_visible", pixel_visible_i, want.visible);
          if (last_pixel_i !== want.last)
            report_mismatch("last_pixel", last_pixel_i, want.last);
          if (no_pixel_i !== want.no_pixel)
            report_mismatch("no_pixel", no_pixel_i, want.no_pixel);
        end
      end
      if (start_i && !busy_i) begin
        if (req_type_i == REQ_LOAD) begin
          setup_line(start_x_i, start_y_i, end_x_i, end_y_i);
        end else begin
          trace_pixel(want);
          pixel_q.push_back(want);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        if (cfg_index_i == CFG_CLIP_X_MAX)      clip_x = cfg_data_i;
        else if (cfg_index_i == CFG_CLIP_Y_MAX) clip_y = cfg_data_i;
      end
      pending_o <= pixel_q.size();
    end
  end

endmodule

// File: dv/midpoint_line_rasterizer_tb.sv
`timescale 1ns / 100ps
// Testbench top for midpoint_line_rasterizer: clock, reset, load/step and clip
// requests, verdict. Prediction and compare live in midpoint_line_rasterizer_checker.
module midpoint_line_rasterizer_tb import mlr_pkg::*;;

  localparam int unsigned CB = COORD_BITS_DEF;
  localparam int COORD_MAX = (1 << (CB - 1)) - 1;
  localparam int COORD_MIN = -COORD_MAX - 1;
  localparam int CLIP_MAX  = (1 << CLIP_W) - 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;
  localparam int NUM_PHASES      = 6;
  localparam int DIRECTED_ITEMS  = 25;
  localparam int ITEMS_PER_PHASE = 105;
  localparam int CYCLE_LIMIT     = 200000;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start_i;
  logic                 busy_o;
  logic                 req_type_i;
  logic signed [CB-1:0] start_x_i, start_y_i, end_x_i, end_y_i;
  logic                 pixel_valid_o;
  logic signed [CB-1:0] pixel_x_o, pixel_y_o;
  logic                 pixel_visible_o, last_pixel_o, no_pixel_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CLIP_W-1:0]    cfg_data_i;

  int mismatches, pending;
  int items;
  int cycle_count = 0;
  int win_x, win_y;
  bit gaps_on, idle_ok;

  midpoint_line_rasterizer #(.COORD_BITS(CB)) i_dut (.*);

  midpoint_line_rasterizer_checker #(.COORD_BITS(CB)) i_checker (
    .clk_i,
    .rst_ni,
    .start_i,
    .busy_i          (busy_o),
    .req_type_i,
    .start_x_i,
    .start_y_i,
    .end_x_i,
    .end_y_i,
    .pixel_valid_i   (pixel_valid_o),
    .pixel_x_i       (pixel_x_o),
    .pixel_y_i       (pixel_y_o),
    .pixel_visible_i (pixel_visible_o),
    .last_pixel_i    (last_pixel_o),
    .no_pixel_i      (no_pixel_o),
    .cfg_valid_i,
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i,
    .cfg_data_i,
    .mismatch_count_o(mismatches),
    .pending_o       (pending)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[midpoint_line_rasterizer] ERROR");
      $finish;
    end
  end

  function automatic int any_coord();
    return int'($urandom_range(COORD_MAX - COORD_MIN, 0)) + COORD_MIN;
  endfunction

  // coordinate around the clip window, just outside it on both sides
  function automatic int near_window(input int lim);
    int c;
    c = int'($urandom_range(lim + 8, 0)) - 4;
    return (c > COORD_MAX) ? COORD_MAX : c;
  endfunction

  function automatic int offset_end(input int base, input int d);
    return (base + d > COORD_MAX || base + d < COORD_MIN) ? base - d : base + d;
  endfunction

  // start stays high when the next request follows right away
  task automatic issue(input req_e kind, input int sx, input int sy, input int ex,
                       input int ey);
    start_i    <= 1'b1;
    req_type_i <= kind;
    start_x_i  <= CB'(sx);
    start_y_i  <= CB'(sy);
    end_x_i    <= CB'(ex);
    end_y_i    <= CB'(ey);
    do @(posedge clk_i); while (busy_o);
    items++;
  endtask

  task automatic idle_burst();
    if (gaps_on && $urandom_range(5, 0) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk_i);
    end
  endtask

  task automatic draw_steps(input int n);
    repeat (n) begin
      idle_burst();
      // endpoint fields carry noise on steps; the block must ignore them
      issue(REQ_STEP, any_coord(), any_coord(), any_coord(), any_coord());
    end
  endtask

  task automatic load_line(input int sx, input int sy, input int ex, input int ey);
    idle_burst();
    issue(REQ_LOAD, sx, sy, ex, ey);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);  // covers a trailing load's setup cycle
  endtask

  task automatic set_clip(input int cx, input int cy, input bit spare);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= CFG_CLIP_X_MAX;
    cfg_data_i  <= CLIP_W'(cx);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_index_i <= CFG_CLIP_Y_MAX;
    cfg_data_i  <= CLIP_W'(cy);
    do @(posedge clk_i); while (!cfg_ready_o);
    if (spare) begin
      cfg_index_i <= CFG_IDX_W'($urandom_range(CFG_IDX_SPARE_HI, CFG_IDX_SPARE_LO));
      cfg_data_i  <= CLIP_W'($urandom);
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    win_x = cx;
    win_y = cy;
  endtask

  task automatic random_sequence();
    int kind, span, dx, dy, sx, sy, major, n;
    gaps_on = idle_ok && ($urandom_range(3, 0) != 0);
    kind = $urandom_range(99, 0);
    if (kind < 75) begin
      // complete lines, mostly short, rarely long
      if ($urandom_range(49, 0) == 0)     span = $urandom_range(200, 65);
      else if ($urandom_range(6, 0) == 0) span = $urandom_range(64, 13);
      else                                span = $urandom_range(12, 0);
      dx = $urandom_range(span, 0);
      dy = $urandom_range(span, 0);
      if ($urandom_range(1, 0)) dx = -dx;
      if ($urandom_range(7, 0) == 0) dy = $urandom_range(1, 0) ? dx : -dx;
      else if ($urandom_range(1, 0)) dy = -dy;
      sx = ($urandom_range(3, 0) == 0) ? any_coord() : near_window(win_x);
      sy = ($urandom_range(3, 0) == 0) ? any_coord() : near_window(win_y);
      load_line(sx, sy, offset_end(sx, dx), offset_end(sy, dy));
      major = (dx < 0) ? -dx : dx;
      if (dy > major)       major = dy;
      else if (-dy > major) major = -dy;
      n = $urandom_range(9, 0);
      if (n == 0)      n = major + $urandom_range(3, 1);  // run past the end
      else if (n == 1) n = $urandom_range(major, 0);      // abandon midway
      else             n = major;
      draw_steps(n);
    end else if (kind < 85) begin
      load_line(any_coord(), any_coord(), any_coord(), any_coord());
      draw_steps($urandom_range(6, 0));
    end else if (kind < 92) begin
      sx = any_coord();
      sy = any_coord();
      load_line(sx, sy, sx, sy);
      draw_steps($urandom_range(2, 1));
    end else begin
      draw_steps($urandom_range(3, 1));
    end
  endtask

  initial begin
    rst_ni      <= 1'b0;
    start_i     <= 1'b0;
    req_type_i  <= REQ_LOAD;
    start_x_i   <= '0;
    start_y_i   <= '0;
    end_x_i     <= '0;
    end_y_i     <= '0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CFG_CLIP_X_MAX;
    cfg_data_i  <= '0;
    items   = 0;
    gaps_on = 1'b0;
    idle_ok = 1'b1;
    win_x   = CLIP_X_RESET;
    win_y   = CLIP_Y_RESET;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: no line, empty line, the four diagonals, extreme endpoints
    draw_steps(1);
    load_line(5, 5, 5, 5);
    draw_steps(1);
    load_line(3, 3, 5, 5);
    draw_steps(2);
    load_line(3, 3, 5, 1);
    draw_steps(2);
    load_line(3, 3, 1, 5);
    draw_steps(2);
    load_line(3, 3, 1, 1);
    draw_steps(2);
    load_line(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
    draw_steps(2);
    load_line(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
    draw_steps(2);
    load_line(0, COORD_MIN, 1, COORD_MAX);
    draw_steps(1);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      if (phase > 0) begin
        wait_drained();
        unique case (phase)
          1:       set_clip(40, 30, 1'b0);
          2:       set_clip(CLIP_MAX, CLIP_MAX, 1'b0);
          3:       set_clip(1, 0, 1'b1);
          4:       set_clip(0, 1, 1'b1);
          default: set_clip($urandom_range(CLIP_MAX, 1), $urandom_range(CLIP_MAX, 0), 1'b0);
        endcase
      end
      idle_ok = (phase < NUM_PHASES - 1);
      while (items < DIRECTED_ITEMS + ITEMS_PER_PHASE * (phase + 1)) random_sequence();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[midpoint_line_rasterizer] OK");
    end else begin
      $display("[midpoint_line_rasterizer] ERROR");
    end
    $finish;
  end

endmodule
